// ----- hw/rtl/dpf_pkg.sv -----
package dpf_pkg;

  localparam int unsigned ValueBits   = 31;
  // A trial divisor never passes floor(sqrt(2^ValueBits)) + 1.
  localparam int unsigned DivBits     = (ValueBits + 1) / 2 + 1;
  // Square of the trial divisor; stays below 2^(ValueBits+1).
  localparam int unsigned SqBits      = ValueBits + 1;
  localparam int unsigned ResultLimit = 9;
  localparam int unsigned CountBits   = $clog2(ResultLimit + 1);
  localparam int unsigned BitCntBits  = $clog2(ValueBits);

  typedef logic [ValueBits-1:0] value_t;
  typedef logic [DivBits-1:0]   div_t;
  typedef logic [SqBits-1:0]    sq_t;
  typedef logic [CountBits-1:0] count_t;
  typedef logic [BitCntBits-1:0] bitcnt_t;

  typedef enum logic [4:0] {
    StIdle   = 5'b00001,
    StCheck  = 5'b00010,
    StDiv    = 5'b00100,
    StFinish = 5'b01000,
    StLast   = 5'b10000
  } state_e;

endpackage

// ----- hw/rtl/distinct_prime_factors.sv -----
// Distinct prime factors by trial division. A request is taken when start_i is
// high and busy_o is low; number_i is then factored and its distinct primes come
// out in ascending order, one per valid_o pulse, the final one flagged by last_o.
// Inputs below two give a single pulse with prime_o = 0, last_o = 1 and
// no_factor_o = 1 in the cycle after the request, and the block stays free.
// The receiver cannot stall: each result is on the ports for exactly one cycle
// with valid_o high and must be taken then. Every trial divisor costs one
// bit-serial restoring division plus the square test in StCheck; each extra
// division that strips a repeated factor costs another division, and the
// wind-down passes through StFinish and, when two primes remain, StLast. The
// total is data dependent and worst for a prime near 2^31. The bit-serial
// divider is the only arithmetic loop, so the divider sets the rate. Searching
// stops at nine results.
module distinct_prime_factors import dpf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [ValueBits-1:0] number_i,
  output logic                 busy_o,
  output logic                 valid_o,
  output logic [ValueBits-1:0] prime_o,
  output logic                 last_o,
  output logic                 no_factor_o
);

  state_e  state_q, state_d;

  // Working remainder and trial divisor with its running square.
  value_t  rem_q, rem_d;
  div_t    div_q, div_d;
  sq_t     sq_q, sq_d;

  // Divider: quotient shift register (starts as dividend) and partial remainder.
  value_t  quo_q, quo_d;
  div_t    part_q, part_d;
  bitcnt_t bit_cnt_q, bit_cnt_d;

  // Current divisor already recorded as a prime; number of primes found.
  logic    hit_q, hit_d;
  count_t  count_q, count_d;

  // One prime held back so the last one can be flagged.
  logic    pend_v_q, pend_v_d;
  value_t  pend_q, pend_d;

  // Output register.
  logic    valid_q, valid_d;
  value_t  prime_q, prime_d;
  logic    last_q, last_d;
  logic    nf_q, nf_d;

  // One restoring division step.
  logic [DivBits:0] part_shift;
  logic             step_ge;
  div_t             part_next;
  value_t           quo_next;

  assign part_shift = {part_q, quo_q[ValueBits-1]};
  assign step_ge    = part_shift >= {1'b0, div_q};
  assign part_next  = step_ge ? DivBits'(part_shift - {1'b0, div_q})
                              : DivBits'(part_shift);
  assign quo_next   = {quo_q[ValueBits-2:0], step_ge};

  logic more_trials;
  logic rem_left;

  assign more_trials = ({1'b0, rem_q} >= sq_q) && (count_q < count_t'(ResultLimit));
  assign rem_left    = (rem_q > value_t'(1)) && (count_q < count_t'(ResultLimit));

  always_comb begin
    state_d   = state_q;
    rem_d     = rem_q;
    div_d     = div_q;
    sq_d      = sq_q;
    quo_d     = quo_q;
    part_d    = part_q;
    bit_cnt_d = bit_cnt_q;
    hit_d     = hit_q;
    count_d   = count_q;
    pend_v_d  = pend_v_q;
    pend_d    = pend_q;
    valid_d   = 1'b0;
    prime_d   = prime_q;
    last_d    = last_q;
    nf_d      = nf_q;

    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          rem_d   = number_i;
          div_d   = div_t'(2);
          if (number_i[ValueBits-1:1] == '0) begin
            // no prime factor: answer at once
            valid_d = 1'b1;
            prime_d = '0;
            last_d  = 1'b1;
            nf_d    = 1'b1;
          end else begin
            sq_d     = sq_t'(4);
            hit_d    = 1'b0;
            count_d  = '0;
            pend_v_d = 1'b0;
            state_d  = StCheck;
          end
        end
      end

      StCheck: begin
        if (more_trials) begin
          quo_d     = rem_q;
          part_d    = '0;
          bit_cnt_d = bitcnt_t'(ValueBits - 1);
          state_d   = StDiv;
        end else begin
          state_d = StFinish;
        end
      end

      StDiv: begin
        quo_d     = quo_next;
        part_d    = part_next;
        bit_cnt_d = bit_cnt_q - bitcnt_t'(1);
        if (bit_cnt_q == '0) begin
          if (part_next == '0) begin
            // divides: strip it and try again with the same divisor
            rem_d     = quo_next;
            part_d    = '0;
            bit_cnt_d = bitcnt_t'(ValueBits - 1);
            if (!hit_q) begin
              hit_d    = 1'b1;
              count_d  = count_q + count_t'(1);
              pend_v_d = 1'b1;
              pend_d   = ValueBits'(div_q);
              if (pend_v_q) begin
                valid_d = 1'b1;
                prime_d = pend_q;
                last_d  = 1'b0;
                nf_d    = 1'b0;
              end
            end
          end else begin
            // next divisor: (d+1)^2 = d^2 + 2d + 1
            div_d   = div_q + div_t'(1);
            sq_d    = sq_q + SqBits'({div_q, 1'b1});
            hit_d   = 1'b0;
            state_d = StCheck;
          end
        end
      end

      StFinish: begin
        valid_d = 1'b1;
        nf_d    = 1'b0;
        if (rem_left && pend_v_q) begin
          prime_d = pend_q;
          last_d  = 1'b0;
          pend_d  = rem_q;
          state_d = StLast;
        end else if (rem_left) begin
          prime_d = rem_q;
          last_d  = 1'b1;
          state_d = StIdle;
        end else begin
          prime_d = pend_q;
          last_d  = 1'b1;
          state_d = StIdle;
        end
      end

      StLast: begin
        valid_d = 1'b1;
        prime_d = pend_q;
        last_d  = 1'b1;
        nf_d    = 1'b0;
        state_d = StIdle;
      end

      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      rem_q    <= '0;
      div_q    <= div_t'(2);
      valid_q  <= 1'b0;
      pend_v_q <= 1'b0;
      hit_q    <= 1'b0;
      count_q  <= '0;
    end else begin
      state_q  <= state_d;
      rem_q    <= rem_d;
      div_q    <= div_d;
      valid_q  <= valid_d;
      pend_v_q <= pend_v_d;
      hit_q    <= hit_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q      <= sq_d;
    quo_q     <= quo_d;
    part_q    <= part_d;
    bit_cnt_q <= bit_cnt_d;
    pend_q    <= pend_d;
    prime_q   <= prime_d;
    last_q    <= last_d;
    nf_q      <= nf_d;
  end

  assign busy_o      = (state_q != StIdle);
  assign valid_o     = valid_q;
  assign prime_o     = prime_q;
  assign last_o      = last_q;
  assign no_factor_o = nf_q;

endmodule
